/* src/vwapdev_pkg.sv */
// shared constants, types and command/status structs of the vwap deviation window
package vwapdev_pkg;

	localparam int WINDOW_MAX = 256;
	localparam int FRAC_BITS  = 16;

	localparam int PRICE_W = 24;
	localparam int VOL_W   = 32;
	localparam int PROD_W  = PRICE_W + VOL_W;
	localparam int SPV_W   = 64;
	localparam int SV_W    = 40;
	localparam int DEV_W   = 32;
	localparam int STAT_W  = 2;
	localparam int CFG_W   = 9;

	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int FILL_W = $clog2(WINDOW_MAX + 1);
	localparam int WIN_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

	// quotient bits below the saturation bound of a 32-bit signed result
	localparam int QUO_W     = DEV_W - 1;
	localparam int PRE_SHIFT = QUO_W - FRAC_BITS;
	localparam int CNT_W     = $clog2(QUO_W);

	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(50);

	localparam logic [DEV_W-1:0] DEV_MAX = {1'b0, {(DEV_W-1){1'b1}}};
	localparam logic [DEV_W-1:0] DEV_MIN = {1'b1, {(DEV_W-1){1'b0}}};

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_VOL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_VWAP = 2'd2;

	typedef enum logic [1:0] {
		MUL_OLD,
		MUL_NEW,
		MUL_SV_LO,
		MUL_SV_HI
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ring_upd;
		logic     sum_sub;
		logic     sum_add;
		logic     a_lo;
		logic     a_hi;
		logic     prep;
		logic     ovf_chk;
		logic     div_step;
		logic     load_out;
		logic     clear;
	} vwapdev_cmd_t;

	typedef struct packed {
		logic sv_zero;
		logic spv_zero;
		logic sat;
	} vwapdev_stat_t;

endpackage

/* src/vwap_deviation_window.sv */
// top level of the vwap deviation window: sequencer plus datapath
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  bar in  | in_valid, in_ready, close_price, bar_volume | in
//  result  | out_valid, out_ready, deviation, status  | out
//  config  | cfg_valid, cfg_ready, cfg_data           | in
//
// a bar is accepted in idle; its result is registered after the window update when a sum
// is zero, after the overflow check when the quotient saturates and after the 31-step
// restoring divider otherwise; the next bar is taken only once that result is loaded.
// reset clears the sums, fill count and write slot and sets the window to 50;
// the ring needs no clearing pass. a finished result waits in the output
// register while the next bar is taken; a new result waits until it is free.
module vwap_deviation_window import vwapdev_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PRICE_W-1:0]      close_price,
	input  logic [VOL_W-1:0]        bar_volume,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [DEV_W-1:0] deviation,
	output logic [STAT_W-1:0]       status,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data
);

	vwapdev_cmd_t  cmd;
	vwapdev_stat_t stat;

	vwapdev_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vwapdev_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_data    (cfg_data),
		.close_price (close_price),
		.bar_volume  (bar_volume),
		.deviation   (deviation),
		.status      (status)
	);

endmodule

/* src/vwapdev_ram.sv */
// generic simple dual-port ram with registered read
module vwapdev_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/vwapdev_ctrl.sv */
// sequencer: steps one bar through window update, vwap check and division
module vwapdev_ctrl import vwapdev_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  vwapdev_stat_t stat,
	output vwapdev_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVICT,
		S_SUB,
		S_ADD,
		S_CHK,
		S_AHI,
		S_ASUM,
		S_PREP,
		S_OVF,
		S_DIV,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = MUL_NEW;
		cmd.clear    = cfg_valid && cfg_ready;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid && in_ready;
			end
			S_EVICT: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_OLD;
				cmd.ring_upd = 1'b1;
			end
			S_SUB: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_NEW;
				cmd.sum_sub = 1'b1;
			end
			S_ADD: begin
				cmd.sum_add = 1'b1;
			end
			S_CHK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SV_LO;
			end
			S_AHI: begin
				cmd.a_lo    = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SV_HI;
			end
			S_ASUM: begin
				cmd.a_hi = 1'b1;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
			end
			S_OVF: begin
				cmd.ovf_chk = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_EVICT;
					end
				end
				S_EVICT: state_q <= S_SUB;
				S_SUB:   state_q <= S_ADD;
				S_ADD:   state_q <= S_CHK;
				S_CHK: begin
					// zero sums skip the quotient
					if (stat.sv_zero || stat.spv_zero) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_AHI;
					end
				end
				S_AHI:  state_q <= S_ASUM;
				S_ASUM: state_q <= S_PREP;
				S_PREP: state_q <= S_OVF;
				S_OVF: begin
					cnt_q <= '0;
					if (stat.sat) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/vwapdev_dp.sv */
// datapath: bar ring, running sums, shared multiplier, restoring divider, result register
module vwapdev_dp import vwapdev_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  vwapdev_cmd_t              cmd,
	output vwapdev_stat_t             stat,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic [PRICE_W-1:0]        close_price,
	input  logic [VOL_W-1:0]          bar_volume,
	output logic signed [DEV_W-1:0]   deviation,
	output logic [STAT_W-1:0]         status
);

	localparam int RING_W = PRICE_W + VOL_W;

	// window state
	logic [CFG_W-1:0]  window_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SPV_W-1:0]  spv_q;
	logic [SV_W-1:0]   sv_q;

	// per-bar working registers
	logic [PRICE_W-1:0] price_q;
	logic [VOL_W-1:0]   vol_q;
	logic               active_q;
	logic               evict_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SPV_W-1:0]   a_q;
	logic               neg_q;
	logic [SPV_W-1:0]   rem_q;
	logic [QUO_W-1:0]   lo_q;
	logic [QUO_W-1:0]   quo_q;
	logic               sat_q;

	logic [WIN_W-1:0]   win;
	logic [WIN_W:0]     slot_ext;
	logic [WIN_W:0]     old_full;
	logic [SLOT_W-1:0]  old_slot;
	logic [RING_W-1:0]  ring_rdata;
	logic [PRICE_W-1:0] old_price;
	logic [VOL_W-1:0]   old_vol;
	logic [PRICE_W-1:0] mul_a;
	logic [VOL_W-1:0]   mul_b;
	logic [SPV_W-1:0]   mag;
	logic [SPV_W-1:0]   mag_hi;
	logic [SPV_W:0]     r2;
	logic               take;
	logic [DEV_W-1:0]   quo_ext;
	logic [DEV_W-1:0]   dev_next;

	always_comb begin
		if (WIN_W'(window_q) > WIN_W'(WINDOW_MAX)) begin
			win = WIN_W'(WINDOW_MAX);
		end else begin
			win = WIN_W'(window_q);
		end
	end

	// slot of the bar that leaves the window
	assign slot_ext = (WIN_W + 1)'(slot_q);
	always_comb begin
		if (slot_ext >= {1'b0, win}) begin
			old_full = slot_ext - {1'b0, win};
		end else begin
			old_full = slot_ext + (WIN_W + 1)'(WINDOW_MAX) - {1'b0, win};
		end
	end
	assign old_slot = old_full[SLOT_W-1:0];

	vwapdev_ram #(
		.WIDTH (RING_W),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring_upd && active_q),
		.waddr (slot_q),
		.wdata ({price_q, vol_q}),
		.re    (cmd.capture),
		.raddr (old_slot),
		.rdata (ring_rdata)
	);

	assign old_price = ring_rdata[RING_W-1:VOL_W];
	assign old_vol   = ring_rdata[VOL_W-1:0];

	always_comb begin
		case (cmd.mul_sel)
			MUL_OLD: begin
				mul_a = old_price;
				mul_b = old_vol;
			end
			MUL_SV_LO: begin
				mul_a = price_q;
				mul_b = sv_q[VOL_W-1:0];
			end
			MUL_SV_HI: begin
				mul_a = price_q;
				mul_b = VOL_W'(sv_q[SV_W-1:VOL_W]);
			end
			default: begin
				mul_a = price_q;
				mul_b = vol_q;
			end
		endcase
	end

	assign mag    = neg_q ? (spv_q - a_q) : (a_q - spv_q);
	assign mag_hi = mag >> PRE_SHIFT;

	// one restoring step, remainder stays below the divisor
	assign r2   = {rem_q, lo_q[QUO_W-1]};
	assign take = (r2 >= {1'b0, spv_q});

	assign stat.sv_zero  = (sv_q == '0);
	assign stat.spv_zero = (spv_q == '0);
	assign stat.sat      = (mag_hi >= spv_q);

	assign quo_ext = {1'b0, quo_q};
	always_comb begin
		if (sat_q) begin
			dev_next = neg_q ? DEV_MIN : DEV_MAX;
		end else begin
			dev_next = neg_q ? (DEV_W'(0) - quo_ext) : quo_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			fill_q   <= '0;
			slot_q   <= '0;
			spv_q    <= '0;
			sv_q     <= '0;
		end else if (cmd.clear) begin
			window_q <= cfg_data;
			fill_q   <= '0;
			slot_q   <= '0;
			spv_q    <= '0;
			sv_q     <= '0;
		end else begin
			if (cmd.ring_upd && active_q) begin
				if (!evict_q) begin
					fill_q <= fill_q + 1'b1;
				end
				if (slot_q == SLOT_W'(WINDOW_MAX - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (cmd.sum_sub && evict_q) begin
				spv_q <= spv_q - SPV_W'(prod_q);
				sv_q  <= sv_q - SV_W'(old_vol);
			end
			if (cmd.sum_add && active_q) begin
				spv_q <= spv_q + SPV_W'(prod_q);
				sv_q  <= sv_q + SV_W'(vol_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			price_q  <= close_price;
			vol_q    <= bar_volume;
			active_q <= (win != '0);
			evict_q  <= (win != '0) && (WIN_W'(fill_q) >= win);
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.a_lo) begin
			a_q <= SPV_W'(prod_q);
		end
		if (cmd.a_hi) begin
			a_q <= a_q + {prod_q[VOL_W-1:0], {(SPV_W-VOL_W){1'b0}}};
		end
		if (cmd.prep) begin
			neg_q <= (a_q < spv_q);
		end
		if (cmd.ovf_chk) begin
			// integer part at or above the bound saturates
			sat_q <= stat.sat;
			// divider setup needs mag from neg_q, so it runs in the state after prep
			rem_q <= mag_hi;
			lo_q  <= {mag[PRE_SHIFT-1:0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (take) begin
				rem_q <= SPV_W'(r2 - {1'b0, spv_q});
			end else begin
				rem_q <= r2[SPV_W-1:0];
			end
			lo_q  <= {lo_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
		if (cmd.load_out) begin
			if (stat.sv_zero) begin
				deviation <= '0;
				status    <= STAT_NO_VOL;
			end else if (stat.spv_zero) begin
				deviation <= '0;
				status    <= STAT_NO_VWAP;
			end else begin
				deviation <= dev_next;
				status    <= STAT_OK;
			end
		end
	end

endmodule
